// ===== rtl/core/pis_pkg.sv =====
// Shared types, constants and arithmetic helpers for the point-in-sphere-set tester.
// Used by pis_cell and point_in_sphere_set_test_top; depends on nothing else.
package pis_pkg;

  // Default sizing
  localparam int MAX_SPHERES_DEF = 16;
  localparam int COORD_BITS_DEF  = 32;

  // Pipeline depth of one cell, point register to hit flag
  localparam int CELL_LAT = 5;

  // Hardware table limit set by the 4-bit entry index
  localparam int IDX_BITS  = 4;
  localparam int IDX_SLOTS = 1 << IDX_BITS;
  localparam int CNT_BITS  = 5;
  localparam int OFS_BITS  = 30;
  localparam int RSUM_BITS = OFS_BITS + 1;
  localparam int RSQ_BITS  = 2 * RSUM_BITS;

  // Configuration register indexes
  typedef enum logic {
    REG_SPHERE_COUNT  = 1'b0,
    REG_RADIUS_OFFSET = 1'b1
  } reg_idx_t;

  // Item kinds
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TEST = 1'b1
  } kind_t;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_ADD,
    ST_LD_WR,
    ST_TEST,
    ST_WAIT
  } state_t;

  // Input word
  typedef struct packed {
    logic                kind;
    logic [3:0]          entry_index;
    logic signed [31:0]  coord_x;
    logic signed [31:0]  coord_y;
    logic signed [31:0]  coord_z;
    logic [29:0]         sphere_radius;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic       inside_res;
    logic [3:0] hit_index;
  } out_word_t;

  // Table entry write, broadcast to all cells
  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] idx;
    logic [31:0]         x;
    logic [31:0]         y;
    logic [31:0]         z;
    logic [RSQ_BITS-1:0] rsq;
  } ent_wr_t;

  // Per-cell status toward the sequencer
  typedef struct packed {
    logic done;
    logic found;
  } cell_res_t;

  // Square of a magnitude up to 2^32, saturating at all ones
  function automatic logic [63:0] sq_sat(input logic [32:0] m);
    logic [63:0] p;
    begin
      p = 64'(m[31:0]) * 64'(m[31:0]);
      return m[32] ? '1 : p;
    end
  endfunction

  // 64-bit add saturating at all ones
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    end
  endfunction

endpackage

// ===== rtl/core/pis_cell.sv =====
// One cell of the sphere chain: holds one table entry and tests the passing point.
// Depends on pis_pkg. Point moves one cell per cycle; the search token trails it, aligned
// with each cell's hit flag, and dies at the first hit or at the last walked entry.
module pis_cell #(
  parameter int COORD_BITS = pis_pkg::COORD_BITS_DEF,
  parameter int CELL_IDX   = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pis_pkg::ent_wr_t              wr,
  input  logic [pis_pkg::CNT_BITS-1:0]  cnt_i,
  input  logic signed [COORD_BITS-1:0]  px_i,
  input  logic signed [COORD_BITS-1:0]  py_i,
  input  logic signed [COORD_BITS-1:0]  pz_i,
  output logic signed [COORD_BITS-1:0]  px_o,
  output logic signed [COORD_BITS-1:0]  py_o,
  output logic signed [COORD_BITS-1:0]  pz_o,
  input  logic                          live_i,
  output logic                          live_o,
  output pis_pkg::cell_res_t            res_o
);

  localparam int W = COORD_BITS;

  // Stored entry
  logic signed [W-1:0]              c_r [3];
  logic [pis_pkg::RSQ_BITS-1:0]     rsq_r;

  // Point and arithmetic pipeline
  logic signed [W-1:0]  p_r   [3];
  logic signed [W:0]    d_r   [3];
  logic [W:0]           m_r   [3];
  logic [63:0]          sq_r  [3];
  logic [63:0]          sxy_r;
  logic [63:0]          sz_r;
  logic                 hit_r;
  logic                 live_r;

  logic [W:0]           mag   [3];
  logic [63:0]          d2;
  logic                 last;

  // Entry load
  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == pis_pkg::IDX_BITS'(CELL_IDX)) begin
      c_r[0] <= wr.x[W-1:0];
      c_r[1] <= wr.y[W-1:0];
      c_r[2] <= wr.z[W-1:0];
      rsq_r  <= wr.rsq;
    end
  end

  // Magnitude of each axis difference
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a] = d_r[a][W] ? (-d_r[a]) : d_r[a];
    end
  end

  assign d2 = pis_pkg::sat_add(sxy_r, sz_r);

  // Five-stage distance pipeline
  always_ff @(posedge clk) begin
    p_r[0] <= px_i;
    p_r[1] <= py_i;
    p_r[2] <= pz_i;
    for (int a = 0; a < 3; a++) begin
      d_r[a]  <= {p_r[a][W-1], p_r[a]} - {c_r[a][W-1], c_r[a]};
      m_r[a]  <= mag[a];
      sq_r[a] <= pis_pkg::sq_sat(33'(m_r[a]));
    end
    sxy_r <= pis_pkg::sat_add(sq_r[0], sq_r[1]);
    sz_r  <= sq_r[2];
    hit_r <= d2 <= 64'(rsq_r);
  end

  // Search token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else begin
      live_r <= live_i;
    end
  end

  assign last       = (cnt_i == pis_pkg::CNT_BITS'(CELL_IDX + 1));
  assign live_o     = live_r & ~hit_r & ~last;
  assign res_o.done  = live_r & (hit_r | last);
  assign res_o.found = live_r & hit_r;

  assign px_o = p_r[0];
  assign py_o = p_r[1];
  assign pz_o = p_r[2];

endmodule

// ===== rtl/core/point_in_sphere_set_test_top.sv =====
// Point-in-union-of-spheres tester, top level. Depends on pis_pkg and pis_cell.
// Load word: states ST_LD_ADD (radius add) and ST_LD_WR (square, write) lie between its accept and the next.
// Test word: result strobe once the search token stops, after n spheres walked
// (index of first hit plus one, or the count on a miss); straight from ST_TEST at count zero.
// Next word taken at the earliest on the strobe's closing edge (receiver never stalls);
// the one-cell-per-cycle chain walk sets it. Sync reset clears control and the configuration registers.
module point_in_sphere_set_test_top #(
  parameter int MAX_SPHERES = pis_pkg::MAX_SPHERES_DEF,
  parameter int COORD_BITS  = pis_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel
  input  logic                start,
  output logic                busy,
  input  pis_pkg::in_word_t   in_word,
  // Result channel
  output logic                out_valid,
  output pis_pkg::out_word_t  out_word,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Only slots reachable by the 4-bit index get a cell
  localparam int N_CELLS = (MAX_SPHERES < pis_pkg::IDX_SLOTS) ? MAX_SPHERES : pis_pkg::IDX_SLOTS;
  localparam int W       = COORD_BITS;
  localparam int CB      = pis_pkg::CNT_BITS;

  pis_pkg::state_t                  state_r, state_nxt;
  pis_pkg::in_word_t                item_r;
  logic [CB-1:0]                    count_r;
  logic [pis_pkg::OFS_BITS-1:0]     offset_r;
  logic [pis_pkg::RSUM_BITS-1:0]    rsum_r;
  logic [pis_pkg::CELL_LAT-1:0]     dly_r;
  logic                             out_valid_r, out_valid_nxt;
  pis_pkg::out_word_t               out_word_r, out_word_nxt;

  logic                             accept;
  logic                             launch;
  logic                             cfg_wr;
  logic [CB-1:0]                    n_eff;
  pis_pkg::ent_wr_t                 ent_wr;

  logic signed [W-1:0]              px_w [N_CELLS];
  logic signed [W-1:0]              py_w [N_CELLS];
  logic signed [W-1:0]              pz_w [N_CELLS];
  logic                             live_w [N_CELLS];
  pis_pkg::cell_res_t               res_w [N_CELLS];

  logic                             any_done;
  logic                             any_found;
  logic [pis_pkg::IDX_BITS-1:0]     hit_idx;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      offset_r <= '0;
    end else if (cfg_wr) begin
      unique case (pis_pkg::reg_idx_t'(paddr[2]))
        pis_pkg::REG_SPHERE_COUNT:  count_r  <= pwdata[CB-1:0];
        pis_pkg::REG_RADIUS_OFFSET: offset_r <= pwdata[pis_pkg::OFS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (pis_pkg::reg_idx_t'(paddr[2]))
      pis_pkg::REG_SPHERE_COUNT:  prdata = 32'(count_r);
      pis_pkg::REG_RADIUS_OFFSET: prdata = 32'(offset_r);
      default:                    prdata = '0;
    endcase
  end

  // Walk length, clipped to the chain
  assign n_eff = (count_r > CB'(N_CELLS)) ? CB'(N_CELLS) : count_r;

  assign busy   = (state_r != pis_pkg::ST_IDLE);
  assign accept = start & ~busy;

  // Item capture and radius sum
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_word;
    end
    rsum_r <= pis_pkg::RSUM_BITS'(item_r.sphere_radius) + pis_pkg::RSUM_BITS'(offset_r);
  end

  // Entry write, squared radius formed on the way
  always_comb begin
    ent_wr.en  = (state_r == pis_pkg::ST_LD_WR);
    ent_wr.idx = item_r.entry_index;
    ent_wr.x   = item_r.coord_x;
    ent_wr.y   = item_r.coord_y;
    ent_wr.z   = item_r.coord_z;
    ent_wr.rsq = pis_pkg::RSQ_BITS'(rsum_r) * pis_pkg::RSQ_BITS'(rsum_r);
  end

  // Cell chain
  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    logic signed [W-1:0] xi, yi, zi;
    logic                li;
    if (k == 0) begin : g_head
      assign xi = item_r.coord_x[W-1:0];
      assign yi = item_r.coord_y[W-1:0];
      assign zi = item_r.coord_z[W-1:0];
      assign li = dly_r[pis_pkg::CELL_LAT-1];
    end else begin : g_body
      assign xi = px_w[k-1];
      assign yi = py_w[k-1];
      assign zi = pz_w[k-1];
      assign li = live_w[k-1];
    end

    pis_cell #(
      .COORD_BITS (COORD_BITS),
      .CELL_IDX   (k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .wr     (ent_wr),
      .cnt_i  (n_eff),
      .px_i   (xi),
      .py_i   (yi),
      .pz_i   (zi),
      .px_o   (px_w[k]),
      .py_o   (py_w[k]),
      .pz_o   (pz_w[k]),
      .live_i (li),
      .live_o (live_w[k]),
      .res_o  (res_w[k])
    );
  end

  // Collect the single finishing cell
  always_comb begin
    any_done  = 1'b0;
    any_found = 1'b0;
    hit_idx   = '0;
    for (int k = 0; k < N_CELLS; k++) begin
      any_done  = any_done | res_w[k].done;
      any_found = any_found | res_w[k].found;
      if (res_w[k].found) begin
        hit_idx = hit_idx | pis_pkg::IDX_BITS'(k);
      end
    end
  end

  // Token launch delay, aligns the token with cell 0's hit flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_r <= '0;
    end else begin
      dly_r <= {dly_r[pis_pkg::CELL_LAT-2:0], launch};
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pis_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  // Sequencer next state and outputs
  always_comb begin
    state_nxt     = state_r;
    launch        = 1'b0;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    unique case (state_r)
      pis_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (pis_pkg::kind_t'(in_word.kind) == pis_pkg::KIND_TEST) ?
                      pis_pkg::ST_TEST : pis_pkg::ST_LD_ADD;
        end
      end
      pis_pkg::ST_LD_ADD: state_nxt = pis_pkg::ST_LD_WR;
      pis_pkg::ST_LD_WR:  state_nxt = pis_pkg::ST_IDLE;
      pis_pkg::ST_TEST: begin
        if (n_eff == '0) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '0;
          state_nxt     = pis_pkg::ST_IDLE;
        end else begin
          launch    = 1'b1;
          state_nxt = pis_pkg::ST_WAIT;
        end
      end
      pis_pkg::ST_WAIT: begin
        if (any_done) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.inside_res = any_found;
          out_word_nxt.hit_index  = hit_idx;
          state_nxt               = pis_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pis_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== verif/tb_point_in_sphere_set_test_top.sv =====
// Self-checking testbench for point_in_sphere_set_test_top: loads sphere entries, classifies
// points and checks each result word against an in-bench predictor of the sphere table.
// Depends on pis_pkg and the RTL of the block only.
module tb_point_in_sphere_set_test_top;

  localparam int          TABLE_SLOTS   = 16;
  localparam int          SETTLE_CYCLES = 30;    // longest test walk covers all 16 entries
  localparam int          STALL_LIMIT   = 2000;
  localparam int          PHASE_WORDS   = 270;
  localparam logic [31:0] COORD_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] COORD_MIN     = 32'h8000_0000;
  localparam logic [29:0] RADIUS_MAX    = 30'h3FFF_FFFF;
  localparam logic [31:0] UNIT          = 32'h0001_0000;  // 1.0 in Q16.16

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               start   = 1'b0;
  logic               busy;
  pis_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  pis_pkg::out_word_t out_word;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [2:0]         paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow of the sphere table and registers
  logic [31:0] ctr_x [TABLE_SLOTS];
  logic [31:0] ctr_y [TABLE_SLOTS];
  logic [31:0] ctr_z [TABLE_SLOTS];
  logic [63:0] radius_sq_tab [TABLE_SLOTS];
  logic [30:0] radius_sum_tab [TABLE_SLOTS];
  logic [4:0]  walk_count = '0;
  logic [29:0] radius_pad = '0;

  pis_pkg::out_word_t pending_verdicts[$];
  pis_pkg::out_word_t verdict_head;
  int          sender_idle_pct = 0;
  int          error_count     = 0;
  int          stall_cycles    = 0;
  int          loads_sent      = 0;
  int          tests_sent      = 0;
  int          hits_seen       = 0;
  int          reg_writes      = 0;

  point_in_sphere_set_test_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #10 clk = ~clk;

  // Squared distance along one axis, saturating at all ones
  function automatic logic [63:0] axis_square(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] diff;
    logic [32:0] mag;
    begin
      diff = {a[31], a} - {b[31], b};
      mag  = diff[32] ? (~diff + 33'd1) : diff;
      if (mag[32]) return '1;
      return {32'd0, mag[31:0]} * {32'd0, mag[31:0]};
    end
  endfunction

  function automatic logic [63:0] sum_saturate(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] total;
    begin
      total = {1'b0, a} + {1'b0, b};
      return total[64] ? '1 : total[63:0];
    end
  endfunction

  // First sphere in the walked range that contains the point
  function automatic pis_pkg::out_word_t classify_point(input pis_pkg::in_word_t w);
    pis_pkg::out_word_t verdict;
    logic [63:0]        dist_sq;
    int                 walk;
    logic               found;
    begin
      verdict = '0;
      found   = 1'b0;
      walk    = (walk_count > TABLE_SLOTS) ? TABLE_SLOTS : int'(walk_count);
      for (int i = 0; i < walk; i++) begin
        if (!found) begin
          dist_sq = sum_saturate(axis_square(w.coord_x, ctr_x[i]),
                                 axis_square(w.coord_y, ctr_y[i]));
          dist_sq = sum_saturate(dist_sq, axis_square(w.coord_z, ctr_z[i]));
          if (dist_sq <= radius_sq_tab[i]) begin
            found              = 1'b1;
            verdict.inside_res = 1'b1;
            verdict.hit_index  = 4'(i);
          end
        end
      end
      return verdict;
    end
  endfunction

  function automatic pis_pkg::in_word_t make_load(input logic [3:0] slot,
                                                  input logic [31:0] x,
                                                  input logic [31:0] y, input logic [31:0] z,
                                                  input logic [29:0] radius);
    pis_pkg::in_word_t w;
    begin
      w = '{kind: pis_pkg::KIND_LOAD, entry_index: slot, coord_x: x, coord_y: y,
            coord_z: z, sphere_radius: radius};
      return w;
    end
  endfunction

  function automatic pis_pkg::in_word_t make_point(input logic [31:0] x,
                                                   input logic [31:0] y,
                                                   input logic [31:0] z);
    pis_pkg::in_word_t w;
    begin
      // slot and radius carry noise; the block must ignore them on a test
      w = '{kind: pis_pkg::KIND_TEST, entry_index: 4'($urandom), coord_x: x, coord_y: y,
            coord_z: z, sphere_radius: 30'($urandom)};
      return w;
    end
  endfunction

  // Either anywhere in the coordinate space or in a cluster around the origin
  function automatic logic [31:0] random_coord();
    begin
      if ($urandom_range(1)) return $urandom;
      return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
    end
  endfunction

  function automatic logic [29:0] random_radius();
    int pick;
    begin
      pick = $urandom_range(9);
      if (pick < 2) return 30'($urandom_range(0, 16));
      if (pick < 7) return 30'($urandom_range(0, 32'h0010_0000));
      return 30'($urandom);
    end
  endfunction

  // Coordinate within one radius of a centre on this axis, either side
  function automatic logic [31:0] near_coord(input logic [31:0] c, input logic [30:0] rsum);
    logic [31:0] amt;
    begin
      amt = $urandom_range(0, {1'b0, rsum}) >> $urandom_range(0, 2);
      return $urandom_range(1) ? c - amt : c + amt;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    begin
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
    end
  endtask

  // Send one word; update the shadow table or queue the expected verdict on accept
  task automatic send_word(input pis_pkg::in_word_t w);
    logic [30:0] rsum;
    begin
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
      start   <= 1'b1;
      in_word <= w;
      do @(posedge clk); while (busy);
      start <= 1'b0;
      if (w.kind == pis_pkg::KIND_LOAD) begin
        rsum                          = {1'b0, w.sphere_radius} + {1'b0, radius_pad};
        ctr_x[w.entry_index]          = w.coord_x;
        ctr_y[w.entry_index]          = w.coord_y;
        ctr_z[w.entry_index]          = w.coord_z;
        radius_sum_tab[w.entry_index] = rsum;
        radius_sq_tab[w.entry_index]  = {33'd0, rsum} * {33'd0, rsum};
        loads_sent++;
      end else begin
        pending_verdicts.push_back(classify_point(w));
        tests_sent++;
      end
    end
  endtask

  // APB write: setup cycle, then access cycle; pready is tied high
  task automatic write_reg(input pis_pkg::reg_idx_t idx, input logic [31:0] value);
    begin
      @(posedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == pis_pkg::REG_SPHERE_COUNT) walk_count = value[4:0];
      else radius_pad = value[29:0];
      reg_writes++;
    end
  endtask

  // Drain all verdicts, then give a trailing load time to finish
  task automatic settle_block();
    begin
      while (pending_verdicts.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      while (busy) @(posedge clk);
    end
  endtask

  // Count zero: no entry is walked, every test misses
  task automatic test_empty_walk();
    begin
      write_reg(pis_pkg::REG_SPHERE_COUNT, 32'd0);
      send_word(make_point('0, '0, '0));
      send_word(make_point(COORD_MAX, COORD_MIN, COORD_MAX));
      send_word(make_point($urandom, $urandom, $urandom));
    end
  endtask

  // Fill every slot so later walks never touch an unwritten entry
  task automatic test_table_fill();
    begin
      settle_block();
      write_reg(pis_pkg::REG_RADIUS_OFFSET, 32'd0);
      send_word(make_load(4'd0, '0, '0, '0, '0));
      send_word(make_load(4'd1, COORD_MAX, COORD_MAX, COORD_MAX, 30'd1));
      send_word(make_load(4'd2, COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX));
      send_word(make_load(4'd3, 32'h0010_0000, 32'hFFE0_0000, 32'h0003_0000, 30'(UNIT)));
      for (int s = 4; s < TABLE_SLOTS; s++)
        send_word(make_load(4'(s), random_coord(), random_coord(), random_coord(),
                            random_radius()));
    end
  endtask

  // Exact boundaries, extreme coordinates, saturation and count clamping
  task automatic test_boundaries();
    begin
      settle_block();
      write_reg(pis_pkg::REG_SPHERE_COUNT, 32'd16);
      send_word(make_point('0, '0, '0));                          // zero radius, on centre
      send_word(make_point(COORD_MAX, COORD_MAX, COORD_MAX));
      send_word(make_point(COORD_MAX - 1, COORD_MAX, COORD_MAX)); // on the surface
      send_word(make_point(COORD_MAX - 1, COORD_MAX - 1, COORD_MAX));
      send_word(make_point(COORD_MIN, COORD_MIN, COORD_MIN));
      send_word(make_point(COORD_MAX, COORD_MIN, COORD_MAX));     // distance saturates
      send_word(make_point(32'h0010_0000 + UNIT, 32'hFFE0_0000, 32'h0003_0000));
      send_word(make_point(32'h0010_0000 + UNIT + 1, 32'hFFE0_0000, 32'h0003_0000));
      // count above the table size walks all sixteen
      settle_block();
      write_reg(pis_pkg::REG_SPHERE_COUNT, 32'd31);
      send_word(make_point(ctr_x[15], ctr_y[15], ctr_z[15]));
      settle_block();
      write_reg(pis_pkg::REG_SPHERE_COUNT, 32'd1);
      send_word(make_point(32'd1, '0, '0));
    end
  endtask

  // Offset is folded in at load; a later offset change leaves the entry alone
  task automatic test_offset_latched();
    begin
      settle_block();
      write_reg(pis_pkg::REG_RADIUS_OFFSET, {2'b00, RADIUS_MAX});
      send_word(make_load(4'd4, COORD_MIN, '0, '0, RADIUS_MAX));
      settle_block();
      write_reg(pis_pkg::REG_RADIUS_OFFSET, 32'd0);
      write_reg(pis_pkg::REG_SPHERE_COUNT, 32'd5);
      send_word(make_point(32'hFFFF_FFFE, '0, '0));               // exactly on the surface
      send_word(make_point(32'hFFFF_FFFF, '0, '0));               // one step outside
    end
  endtask

  // Random loads and tests; most tests aim near a stored sphere
  task automatic test_random_traffic(input int idle_pct, input logic [4:0] count,
                                     input logic [29:0] offset);
    pis_pkg::in_word_t w;
    int                j;
    int                walk;
    begin
      settle_block();
      write_reg(pis_pkg::REG_SPHERE_COUNT, {27'd0, count});
      write_reg(pis_pkg::REG_RADIUS_OFFSET, {2'b00, offset});
      sender_idle_pct = idle_pct;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // hold off once mid-phase until every verdict is back
        if (k == PHASE_WORDS / 2) settle_block();
        walk = (walk_count > TABLE_SLOTS) ? TABLE_SLOTS : int'(walk_count);
        if ($urandom_range(3) == 0) begin
          w = make_load(4'($urandom), random_coord(), random_coord(), random_coord(),
                        random_radius());
        end else if (walk != 0 && $urandom_range(9) < 6) begin
          j = $urandom_range(0, walk - 1);
          w = make_point(near_coord(ctr_x[j], radius_sum_tab[j]),
                         near_coord(ctr_y[j], radius_sum_tab[j]),
                         near_coord(ctr_z[j], radius_sum_tab[j]));
        end else begin
          w = make_point(random_coord(), random_coord(), random_coord());
        end
        send_word(w);
      end
    end
  endtask

  // Result checker: compare each verdict word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result word with nothing pending", 32'(out_word), 32'd0);
      end else begin
        verdict_head = pending_verdicts.pop_front();
        if (out_word.inside_res !== verdict_head.inside_res)
          report_mismatch("inside_res", 32'(out_word.inside_res),
                          32'(verdict_head.inside_res));
        if (out_word.hit_index !== verdict_head.hit_index)
          report_mismatch("hit_index", 32'(out_word.hit_index),
                          32'(verdict_head.hit_index));
        if (out_word.inside_res === 1'b1) hits_seen++;
      end
    end
  end

  // Watchdog: cycles in which no word moves in either direction
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: %0d cycles without a word moving", stall_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_walk();
    test_table_fill();
    test_boundaries();
    test_offset_latched();
    test_random_traffic(0, 5'd16, 30'd0);
    test_random_traffic(62, 5'($urandom_range(1, 15)), 30'($urandom));
    test_random_traffic(0, 5'd16, RADIUS_MAX);
    test_random_traffic(36, 5'($urandom_range(1, 16)), 30'($urandom_range(0, 32'hFFFFF)));
    settle_block();
    $display("Run covered %0d sphere loads and %0d point tests (%0d inside, %0d outside)",
             loads_sent, tests_sent, hits_seen, tests_sent - hits_seen);
    $display("over %0d register writes and four sender idle patterns", reg_writes);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pis_pkg.sv
rtl/core/pis_cell.sv
rtl/core/point_in_sphere_set_test_top.sv
verif/tb_point_in_sphere_set_test_top.sv
